>>> rtl/tld_pkg.sv
// Package for the terminal input line discipline: payload structs, command
// codes, register indexes, character constants and the key mapping function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tld_pkg;

  localparam int BUFFER_DEPTH_DEFAULT = 128;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 1;

  typedef enum logic [1:0] {
    FUNC_KEY   = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_CANONICAL  = 3'd0,
    CFG_IGNORE_CR  = 3'd1,
    CFG_CR_TO_NL   = 3'd2,
    CFG_NL_TO_CR   = 3'd3,
    CFG_UPPER_LOW  = 3'd4,
    CFG_ECHO       = 3'd5
  } cfg_index_t;

  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CASE_GAP = 8'h20;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] char_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_char;
    logic       read_valid;
    logic [7:0] echo_char;
    logic       echo_valid;
    logic       erase_echo;
    logic       wake;
    logic       dropped;
    logic       erase_refused;
    logic [7:0] stored_count;
    logic [7:0] lines_pending;
  } out_item_t;

  typedef struct packed {
    logic canonical_mode;
    logic ignore_cr;
    logic cr_to_nl;
    logic nl_to_cr;
    logic upper_to_lower;
    logic echo_enable;
  } cfg_t;

  typedef struct packed {
    logic       skip;
    logic [7:0] ch;
  } key_map_t;

  function automatic logic is_delim(input logic [7:0] c);
    return (c == CH_NL) || (c == CH_CR);
  endfunction

  // Canonical-mode input mapping: carriage return and newline handling, then case folding.
  function automatic key_map_t map_key(input logic [7:0] c, input cfg_t cfg);
    key_map_t m;
    m.skip = 1'b0;
    m.ch   = c;
    if (c == CH_CR) begin
      if (cfg.ignore_cr) begin
        m.skip = 1'b1;
      end else if (cfg.cr_to_nl) begin
        m.ch = CH_NL;
      end
    end else if (c == CH_NL) begin
      if (cfg.nl_to_cr) begin
        m.ch = CH_CR;
      end
    end
    if (cfg.upper_to_lower && (m.ch >= CH_UP_A) && (m.ch <= CH_UP_Z)) begin
      m.ch = m.ch + CASE_GAP;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

>>> rtl/tld_store.sv
// Byte ring storage for the line discipline: one write port and two
// registered read ports (oldest byte and newest byte) with write bypass.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none

module tld_store #(
  parameter int BUFFER_DEPTH = 128,
  parameter int PTR_W        = 7
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [PTR_W-1:0] waddr,
  input  wire logic [7:0]       wdata,
  input  wire logic [PTR_W-1:0] head_addr,
  input  wire logic [PTR_W-1:0] tail_addr,
  output logic      [7:0]       head_data,
  output logic      [7:0]       tail_data
);

  logic [7:0] mem [BUFFER_DEPTH];

  // A byte written in this cycle is forwarded so the next item sees it.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && (waddr == head_addr)) begin
      head_data <= wdata;
    end else begin
      head_data <= mem[head_addr];
    end
    if (we && (waddr == tail_addr)) begin
      tail_data <= wdata;
    end else begin
      tail_data <= mem[tail_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/tld_engine.sv
// Item processing for the line discipline: pointer, full and delimiter
// bookkeeping, key mapping, erase handling and the registered result.
// Depends on tld_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tld_engine #(
  parameter int BUFFER_DEPTH = 128,
  parameter int PTR_W        = 7,
  parameter int CNT_W        = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  input  wire tld_pkg::in_item_t  item,
  input  wire tld_pkg::cfg_t      cfg,
  input  wire logic [7:0]         head_data,
  input  wire logic [7:0]         tail_data,
  output logic                    mem_we,
  output logic      [PTR_W-1:0]   mem_waddr,
  output logic      [7:0]         mem_wdata,
  output logic      [PTR_W-1:0]   head_addr,
  output logic      [PTR_W-1:0]   tail_addr,
  output logic                    done,
  output tld_pkg::out_item_t      out_item
);

  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(BUFFER_DEPTH - 1);
  localparam logic [PTR_W-1:0] PTR_ZERO  = '0;
  localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(BUFFER_DEPTH);

  logic [PTR_W-1:0] write_ptr, write_ptr_next;
  logic [PTR_W-1:0] read_ptr, read_ptr_next;
  logic             full_flag, full_flag_next;
  logic [CNT_W-1:0] delim_count, delim_count_next;

  tld_pkg::out_item_t res_next;
  tld_pkg::key_map_t  mapped;
  logic               do_push;
  logic               canon_wake;
  logic [7:0]         push_ch;
  logic               empty;
  logic [PTR_W-1:0]   wp_inc, wp_dec, rp_inc;
  logic [CNT_W-1:0]   stored_next;
  logic [CNT_W+7:0]   stored_ext, delim_ext;

  assign empty  = (write_ptr == read_ptr) && !full_flag;
  assign wp_inc = (write_ptr == PTR_LAST) ? PTR_ZERO : write_ptr + 1'b1;
  assign wp_dec = (write_ptr == PTR_ZERO) ? PTR_LAST : write_ptr - 1'b1;
  assign rp_inc = (read_ptr == PTR_LAST) ? PTR_ZERO : read_ptr + 1'b1;
  assign mapped = tld_pkg::map_key(item.char_in, cfg);

  always_comb begin
    write_ptr_next   = write_ptr;
    read_ptr_next    = read_ptr;
    full_flag_next   = full_flag;
    delim_count_next = delim_count;
    res_next         = '0;
    do_push          = 1'b0;
    canon_wake       = 1'b0;
    push_ch          = item.char_in;
    mem_we           = 1'b0;
    mem_waddr        = write_ptr;
    mem_wdata        = push_ch;

    if (item_valid) begin
      case (tld_pkg::func_t'(item.func))
        tld_pkg::FUNC_KEY: begin
          if (cfg.canonical_mode) begin
            push_ch = mapped.ch;
            if (mapped.skip) begin
              do_push = 1'b0;
            end else if ((mapped.ch == tld_pkg::CH_DEL) || (mapped.ch == tld_pkg::CH_BS)) begin
              // The newest byte is erased unless it closes a line.
              if (empty || tld_pkg::is_delim(tail_data)) begin
                res_next.erase_refused = 1'b1;
              end else begin
                write_ptr_next      = wp_dec;
                full_flag_next      = 1'b0;
                res_next.erase_echo = 1'b1;
              end
            end else begin
              do_push    = 1'b1;
              canon_wake = 1'b1;
              if (cfg.echo_enable) begin
                res_next.echo_char  = mapped.ch;
                res_next.echo_valid = 1'b1;
              end
            end
          end else begin
            do_push       = 1'b1;
            res_next.wake = 1'b1;
          end
        end
        tld_pkg::FUNC_READ: begin
          if (!empty) begin
            res_next.read_char  = head_data;
            res_next.read_valid = 1'b1;
            full_flag_next      = 1'b0;
            read_ptr_next       = rp_inc;
            if (tld_pkg::is_delim(head_data) && (delim_count != '0)) begin
              delim_count_next = delim_count - 1'b1;
            end
          end
        end
        tld_pkg::FUNC_CLEAR: begin
          write_ptr_next   = PTR_ZERO;
          read_ptr_next    = PTR_ZERO;
          full_flag_next   = 1'b0;
          delim_count_next = '0;
        end
        default: begin
          res_next = '0;
        end
      endcase
    end

    if (do_push) begin
      if (full_flag) begin
        res_next.dropped = 1'b1;
      end else begin
        mem_we         = 1'b1;
        mem_wdata      = push_ch;
        write_ptr_next = wp_inc;
        full_flag_next = (wp_inc == read_ptr);
        if (tld_pkg::is_delim(push_ch)) begin
          delim_count_next = delim_count + 1'b1;
        end
      end
    end

    if (canon_wake) begin
      res_next.wake = (delim_count_next != '0);
    end

    if (full_flag_next) begin
      stored_next = CNT_DEPTH;
    end else if (write_ptr_next >= read_ptr_next) begin
      stored_next = CNT_W'(write_ptr_next) - CNT_W'(read_ptr_next);
    end else begin
      stored_next = CNT_W'(write_ptr_next) + CNT_DEPTH - CNT_W'(read_ptr_next);
    end
    stored_ext             = {8'b0, stored_next};
    delim_ext              = {8'b0, delim_count_next};
    res_next.stored_count  = stored_ext[7:0];
    res_next.lines_pending = delim_ext[7:0];
  end

  // Storage reads for the next item are addressed from the updated pointers.
  assign head_addr = read_ptr_next;
  assign tail_addr = (write_ptr_next == PTR_ZERO) ? PTR_LAST : write_ptr_next - 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      write_ptr   <= '0;
      read_ptr    <= '0;
      full_flag   <= 1'b0;
      delim_count <= '0;
      done        <= 1'b0;
    end else begin
      write_ptr   <= write_ptr_next;
      read_ptr    <= read_ptr_next;
      full_flag   <= full_flag_next;
      delim_count <= delim_count_next;
      done        <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_item <= res_next;
  end

endmodule

`default_nettype wire

>>> rtl/tty_input_line_discipline_top.sv
// Top level of the terminal input line discipline: command register,
// configuration registers, item engine and byte ring storage.
// Depends on tld_pkg, tld_engine and tld_store.
//
// Usage:
//   Command channel: an item (func, char_in) transfers at a rising edge where
//   start is high and busy is low. busy stays low, so one item can transfer
//   in every cycle. func selects a key byte, a read of one byte or a clear.
//   Result channel: every item gives exactly one result on out_item, marked
//   by done for one cycle. The item is registered, processed in one pass
//   against the ring pointers and the registered storage reads, and the
//   result is registered. Throughput is one item per cycle; the figure is
//   set by the pointer update in one pass and the one-write, two-read
//   storage, whose next reads are addressed from the updated pointers.
//   The receiver cannot stall; a result shown while done is high must be
//   taken in that cycle.
//   Configuration: cfg_we writes cfg_data to register cfg_index at the edge.
//   Reset: rst (synchronous) empties the buffer, clears the delimiter count
//   and restores the register defaults. No storage sweep follows reset.
`timescale 1ns / 1ps
`default_nettype none

module tty_input_line_discipline_top #(
  parameter int BUFFER_DEPTH = tld_pkg::BUFFER_DEPTH_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire tld_pkg::in_item_t                   in_item,
  output logic                                     done,
  output tld_pkg::out_item_t                       out_item,
  input  wire logic                                cfg_we,
  input  wire logic [tld_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [tld_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int PTR_W = $clog2(BUFFER_DEPTH);
  localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);

  logic              item_valid;
  tld_pkg::in_item_t item;
  tld_pkg::cfg_t     cfg;

  logic             mem_we;
  logic [PTR_W-1:0] mem_waddr;
  logic [7:0]       mem_wdata;
  logic [PTR_W-1:0] head_addr;
  logic [PTR_W-1:0] tail_addr;
  logic [7:0]       head_data;
  logic [7:0]       tail_data;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      item <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.canonical_mode <= 1'b1;
      cfg.ignore_cr      <= 1'b0;
      cfg.cr_to_nl       <= 1'b1;
      cfg.nl_to_cr       <= 1'b0;
      cfg.upper_to_lower <= 1'b0;
      cfg.echo_enable    <= 1'b1;
    end else if (cfg_we) begin
      case (tld_pkg::cfg_index_t'(cfg_index))
        tld_pkg::CFG_CANONICAL: cfg.canonical_mode <= cfg_data[0];
        tld_pkg::CFG_IGNORE_CR: cfg.ignore_cr      <= cfg_data[0];
        tld_pkg::CFG_CR_TO_NL:  cfg.cr_to_nl       <= cfg_data[0];
        tld_pkg::CFG_NL_TO_CR:  cfg.nl_to_cr       <= cfg_data[0];
        tld_pkg::CFG_UPPER_LOW: cfg.upper_to_lower <= cfg_data[0];
        tld_pkg::CFG_ECHO:      cfg.echo_enable    <= cfg_data[0];
        default: begin
          cfg <= cfg;
        end
      endcase
    end
  end

  tld_engine #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .PTR_W        (PTR_W),
    .CNT_W        (CNT_W)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .cfg        (cfg),
    .head_data  (head_data),
    .tail_data  (tail_data),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .head_addr  (head_addr),
    .tail_addr  (tail_addr),
    .done       (done),
    .out_item   (out_item)
  );

  tld_store #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .PTR_W        (PTR_W)
  ) u_store (
    .clk       (clk),
    .we        (mem_we),
    .waddr     (mem_waddr),
    .wdata     (mem_wdata),
    .head_addr (head_addr),
    .tail_addr (tail_addr),
    .head_data (head_data),
    .tail_data (tail_data)
  );

endmodule

`default_nettype wire

>>> rtl/tld_checker.sv
// Port-level checks for the line discipline top level, attached by bind.
// Depends on tld_pkg and tty_input_line_discipline_top.
`timescale 1ns / 1ps
`default_nettype none

module tld_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               start,
  input wire logic               busy,
  input wire tld_pkg::in_item_t  in_item,
  input wire logic               done,
  input wire tld_pkg::out_item_t out_item
);

  // Every command transfer yields a result, marked by done.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done)
    else $error("command transfer without a result");

  // A result only appears for an earlier command transfer.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result without a command transfer");

  // Popped bytes only come from read commands.
  a_read_source: assert property (@(posedge clk) disable iff (rst)
    (done && out_item.read_valid) |-> ($past(in_item.func, 2) == tld_pkg::FUNC_READ))
    else $error("read byte from a non-read command");

  // An accepted erase removes exactly one stored byte.
  a_erase_count: assert property (@(posedge clk) disable iff (rst)
    (done && $past(done) && out_item.erase_echo) |->
      (out_item.stored_count == $past(out_item.stored_count) - 8'd1))
    else $error("erase did not remove one byte");

endmodule

bind tty_input_line_discipline_top tld_checker u_tld_checker (.*);

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for tty_input_line_discipline_top: directed table, then
// random traffic, checked against a line discipline predictor kept in the bench.
// Depends on tld_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_top;

  localparam int DEPTH = tld_pkg::BUFFER_DEPTH_DEFAULT;
  localparam int PTR_W = $clog2(DEPTH);
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 1000;
  localparam int RANDOM_ITEMS = 900;

  typedef struct packed {
    logic                is_cfg;
    tld_pkg::cfg_index_t reg_idx;
    logic                reg_val;
    tld_pkg::in_item_t   item;
    logic                fixed;
    logic                fix_refused;
    logic [7:0]          fix_count;
    logic [7:0]          fix_lines;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  tld_pkg::in_item_t in_item = '0;
  logic done;
  tld_pkg::out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [tld_pkg::CFG_INDEX_W-1:0] cfg_index = tld_pkg::CFG_CANONICAL;
  logic [tld_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor state: ring contents, pointers, full mark, delimiter count, settings.
  logic [7:0] ring_bytes [DEPTH];
  logic [PTR_W-1:0] ring_wr;
  logic [PTR_W-1:0] ring_rd;
  logic ring_full;
  logic [7:0] ring_lines;
  tld_pkg::cfg_t disc_cfg;

  tld_pkg::out_item_t line_results_q [$];
  stim_row_t table_q [$];
  int error_count = 0;
  int stall_cycles = 0;

  always #1 clk = ~clk;

  tty_input_line_discipline_top u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .done      (done),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  function automatic logic is_line_end(logic [7:0] c);
    return (c == tld_pkg::CH_NL) || (c == tld_pkg::CH_CR);
  endfunction

  function automatic logic ring_empty();
    return (ring_wr == ring_rd) && !ring_full;
  endfunction

  function automatic void ring_clear();
    for (int i = 0; i < DEPTH; i++) begin
      ring_bytes[i] = 8'h00;
    end
    ring_wr = '0;
    ring_rd = '0;
    ring_full = 1'b0;
    ring_lines = 8'd0;
  endfunction

  // Appends one byte; returns 1 when the ring was already full and it is lost.
  function automatic logic store_byte(logic [7:0] c);
    if (ring_full) begin
      return 1'b1;
    end
    ring_bytes[ring_wr] = c;
    ring_wr = ring_wr + 1'b1;
    if (ring_wr == ring_rd) begin
      ring_full = 1'b1;
    end
    if (is_line_end(c)) begin
      ring_lines = ring_lines + 8'd1;
    end
    return 1'b0;
  endfunction

  function automatic tld_pkg::out_item_t next_line_result(tld_pkg::in_item_t it);
    tld_pkg::out_item_t r;
    logic [7:0] c;
    logic skip;
    logic [PTR_W-1:0] last;
    logic [PTR_W-1:0] fill;
    r = '0;
    c = it.char_in;
    skip = 1'b0;
    case (it.func)
      tld_pkg::FUNC_KEY: begin
        if (disc_cfg.canonical_mode) begin
          if (c == tld_pkg::CH_CR) begin
            if (disc_cfg.ignore_cr) begin
              skip = 1'b1;
            end else if (disc_cfg.cr_to_nl) begin
              c = tld_pkg::CH_NL;
            end
          end else if ((c == tld_pkg::CH_NL) && disc_cfg.nl_to_cr) begin
            c = tld_pkg::CH_CR;
          end
          if (disc_cfg.upper_to_lower && (c >= tld_pkg::CH_UP_A)
              && (c <= tld_pkg::CH_UP_Z)) begin
            c = c + tld_pkg::CASE_GAP;
          end
          if (skip) begin
            // A dropped carriage return leaves everything as it was.
          end else if ((c == tld_pkg::CH_DEL) || (c == tld_pkg::CH_BS)) begin
            last = ring_wr - 1'b1;
            if (ring_empty() || is_line_end(ring_bytes[last])) begin
              r.erase_refused = 1'b1;
            end else begin
              ring_bytes[last] = 8'h00;
              ring_wr = last;
              ring_full = 1'b0;
              r.erase_echo = 1'b1;
            end
          end else begin
            // Echo and wake still apply when the byte is dropped.
            r.dropped = store_byte(c);
            r.wake = (ring_lines != 8'd0);
            if (disc_cfg.echo_enable) begin
              r.echo_char = c;
              r.echo_valid = 1'b1;
            end
          end
        end else begin
          r.dropped = store_byte(c);
          r.wake = 1'b1;
        end
      end
      tld_pkg::FUNC_READ: begin
        if (!ring_empty()) begin
          r.read_char = ring_bytes[ring_rd];
          r.read_valid = 1'b1;
          ring_bytes[ring_rd] = 8'h00;
          ring_full = 1'b0;
          ring_rd = ring_rd + 1'b1;
          if (is_line_end(r.read_char) && (ring_lines != 8'd0)) begin
            ring_lines = ring_lines - 8'd1;
          end
        end
      end
      tld_pkg::FUNC_CLEAR: begin
        ring_clear();
      end
      default: begin
      end
    endcase
    fill = ring_wr - ring_rd;
    r.stored_count = ring_full ? 8'(DEPTH) : 8'(fill);
    r.lines_pending = ring_lines;
    return r;
  endfunction

  function automatic stim_row_t row_item(logic [1:0] f, logic [7:0] c);
    stim_row_t r;
    r = '0;
    r.item.func = f;
    r.item.char_in = c;
    return r;
  endfunction

  function automatic stim_row_t row_fixed(logic [1:0] f, logic [7:0] c, logic rf,
                                          logic [7:0] sc, logic [7:0] lp);
    stim_row_t r;
    r = row_item(f, c);
    r.fixed = 1'b1;
    r.fix_refused = rf;
    r.fix_count = sc;
    r.fix_lines = lp;
    return r;
  endfunction

  function automatic stim_row_t row_cfg(tld_pkg::cfg_index_t idx, logic v);
    stim_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.reg_idx = idx;
    r.reg_val = v;
    return r;
  endfunction

  // Drives one item, holds it until the transfer, then files what it must return.
  task automatic send_item(tld_pkg::in_item_t it, logic fixed, tld_pkg::out_item_t want);
    tld_pkg::out_item_t predicted;
    @(negedge clk);
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    predicted = next_line_result(it);
    line_results_q.push_back(fixed ? want : predicted);
  endtask

  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    start <= 1'b0;
    while (line_results_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(tld_pkg::cfg_index_t idx, logic v);
    wait_results_drained();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    case (idx)
      tld_pkg::CFG_CANONICAL: disc_cfg.canonical_mode = v;
      tld_pkg::CFG_IGNORE_CR: disc_cfg.ignore_cr = v;
      tld_pkg::CFG_CR_TO_NL:  disc_cfg.cr_to_nl = v;
      tld_pkg::CFG_NL_TO_CR:  disc_cfg.nl_to_cr = v;
      tld_pkg::CFG_UPPER_LOW: disc_cfg.upper_to_lower = v;
      tld_pkg::CFG_ECHO:      disc_cfg.echo_enable = v;
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    tld_pkg::out_item_t want;
    if (!rst && (done === 1'b1)) begin
      if (line_results_q.size() == 0) begin
        $error("result with no item waiting for it");
        error_count++;
      end else begin
        want = line_results_q.pop_front();
        check_field("read_char", want.read_char, out_item.read_char);
        check_field("read_valid", 8'(want.read_valid), 8'(out_item.read_valid));
        check_field("echo_char", want.echo_char, out_item.echo_char);
        check_field("echo_valid", 8'(want.echo_valid), 8'(out_item.echo_valid));
        check_field("erase_echo", 8'(want.erase_echo), 8'(out_item.erase_echo));
        check_field("wake", 8'(want.wake), 8'(out_item.wake));
        check_field("dropped", 8'(want.dropped), 8'(out_item.dropped));
        check_field("erase_refused", 8'(want.erase_refused), 8'(out_item.erase_refused));
        check_field("stored_count", want.stored_count, out_item.stored_count);
        check_field("lines_pending", want.lines_pending, out_item.lines_pending);
      end
    end
  end

  // Ends the run when nothing moves for too long.
  always @(posedge clk) begin
    if ((start && !busy) || (done === 1'b1) || cfg_we) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    stim_row_t row;
    tld_pkg::out_item_t want;
    tld_pkg::in_item_t it;
    tld_pkg::cfg_t settings;
    int sent;
    int phase;
    int key_pct;
    int phase_left;
    int burst;
    int pick;

    ring_clear();
    disc_cfg = '0;
    disc_cfg.canonical_mode = 1'b1;
    disc_cfg.cr_to_nl = 1'b1;
    disc_cfg.echo_enable = 1'b1;

    // Directed table, starting from the reset settings.
    table_q.push_back(row_fixed(tld_pkg::FUNC_READ, 8'h00, 1'b0, 8'd0, 8'd0));
    table_q.push_back(row_fixed(tld_pkg::FUNC_KEY, tld_pkg::CH_DEL, 1'b1, 8'd0, 8'd0));
    table_q.push_back(row_fixed(tld_pkg::FUNC_KEY, tld_pkg::CH_BS, 1'b1, 8'd0, 8'd0));
    table_q.push_back(row_fixed(FUNC_UNUSED, 8'hFF, 1'b0, 8'd0, 8'd0));
    table_q.push_back(row_item(tld_pkg::FUNC_KEY, 8'h41));
    table_q.push_back(row_item(tld_pkg::FUNC_KEY, 8'h00));
    table_q.push_back(row_item(tld_pkg::FUNC_KEY, 8'hFF));
    table_q.push_back(row_item(tld_pkg::FUNC_KEY, tld_pkg::CH_BS));
    table_q.push_back(row_item(tld_pkg::FUNC_KEY, tld_pkg::CH_CR));
    table_q.push_back(row_fixed(tld_pkg::FUNC_KEY, tld_pkg::CH_DEL, 1'b1, 8'd3, 8'd1));
    table_q.push_back(row_item(tld_pkg::FUNC_KEY, 8'h62));
    table_q.push_back(row_item(tld_pkg::FUNC_READ, 8'h00));
    table_q.push_back(row_item(tld_pkg::FUNC_READ, 8'hFF));
    table_q.push_back(row_item(tld_pkg::FUNC_READ, 8'h00));
    table_q.push_back(row_item(tld_pkg::FUNC_CLEAR, 8'h00));
    table_q.push_back(row_cfg(tld_pkg::CFG_IGNORE_CR, 1'b1));
    table_q.push_back(row_fixed(tld_pkg::FUNC_KEY, tld_pkg::CH_CR, 1'b0, 8'd0, 8'd0));
    table_q.push_back(row_cfg(tld_pkg::CFG_IGNORE_CR, 1'b0));
    table_q.push_back(row_cfg(tld_pkg::CFG_CR_TO_NL, 1'b0));
    table_q.push_back(row_item(tld_pkg::FUNC_KEY, tld_pkg::CH_CR));
    table_q.push_back(row_cfg(tld_pkg::CFG_NL_TO_CR, 1'b1));
    table_q.push_back(row_item(tld_pkg::FUNC_KEY, tld_pkg::CH_NL));
    table_q.push_back(row_cfg(tld_pkg::CFG_UPPER_LOW, 1'b1));
    table_q.push_back(row_item(tld_pkg::FUNC_KEY, 8'h5A));
    table_q.push_back(row_item(tld_pkg::FUNC_KEY, 8'h40));
    table_q.push_back(row_item(tld_pkg::FUNC_KEY, 8'h5B));
    table_q.push_back(row_cfg(tld_pkg::CFG_ECHO, 1'b0));
    table_q.push_back(row_item(tld_pkg::FUNC_KEY, 8'h71));
    table_q.push_back(row_cfg(tld_pkg::CFG_CANONICAL, 1'b0));
    table_q.push_back(row_item(tld_pkg::FUNC_KEY, tld_pkg::CH_DEL));
    table_q.push_back(row_item(tld_pkg::FUNC_KEY, tld_pkg::CH_CR));
    table_q.push_back(row_item(tld_pkg::FUNC_KEY, 8'h41));
    table_q.push_back(row_item(tld_pkg::FUNC_READ, 8'h00));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (table_q[i]) begin
      row = table_q[i];
      if (row.is_cfg) begin
        write_reg(row.reg_idx, row.reg_val);
      end else begin
        want = '0;
        want.erase_refused = row.fix_refused;
        want.stored_count = row.fix_count;
        want.lines_pending = row.fix_lines;
        send_item(row.item, row.fixed, want);
      end
    end

    // Random phases: first all settings on, then all off, then mixed. Typing-heavy
    // phases fill the ring so that drops and erases on a full ring occur.
    sent = 0;
    phase = 0;
    want = '0;
    while (sent < RANDOM_ITEMS) begin
      if (phase == 0) begin
        settings = '1;
        key_pct = 95;
        phase_left = 300;
      end else if (phase == 1) begin
        settings = '0;
        key_pct = 90;
        phase_left = 200;
      end else begin
        settings = tld_pkg::cfg_t'(6'($urandom));
        pick = $urandom_range(0, 2);
        key_pct = (pick == 0) ? 90 : (pick == 1) ? 60 : 30;
        phase_left = $urandom_range(60, 300);
      end
      if (phase_left > RANDOM_ITEMS - sent) begin
        phase_left = RANDOM_ITEMS - sent;
      end
      write_reg(tld_pkg::CFG_CANONICAL, settings.canonical_mode);
      write_reg(tld_pkg::CFG_IGNORE_CR, settings.ignore_cr);
      write_reg(tld_pkg::CFG_CR_TO_NL, settings.cr_to_nl);
      write_reg(tld_pkg::CFG_NL_TO_CR, settings.nl_to_cr);
      write_reg(tld_pkg::CFG_UPPER_LOW, settings.upper_to_lower);
      write_reg(tld_pkg::CFG_ECHO, settings.echo_enable);
      while (phase_left > 0) begin
        burst = $urandom_range(1, 32);
        while ((burst > 0) && (phase_left > 0)) begin
          it = '0;
          if ($urandom_range(0, 99) < key_pct) begin
            it.func = tld_pkg::FUNC_KEY;
            pick = $urandom_range(0, 9);
            case (pick)
              0: it.char_in = tld_pkg::CH_CR;
              1: it.char_in = tld_pkg::CH_NL;
              2: it.char_in = tld_pkg::CH_DEL;
              3: it.char_in = tld_pkg::CH_BS;
              4, 5: it.char_in = tld_pkg::CH_UP_A + 8'($urandom_range(0, 25))
                                 + ($urandom_range(0, 1) ? tld_pkg::CASE_GAP : 8'h00);
              default: it.char_in = 8'($urandom_range(0, 255));
            endcase
          end else begin
            pick = $urandom_range(0, 99);
            it.func = (pick < 94) ? tld_pkg::FUNC_READ
                    : (pick < 97) ? tld_pkg::FUNC_CLEAR : FUNC_UNUSED;
            it.char_in = 8'($urandom_range(0, 255));
          end
          send_item(it, 1'b0, want);
          sent++;
          burst--;
          phase_left--;
        end
        if ($urandom_range(0, 3) != 0) begin
          idle_cycles($urandom_range(1, 10));
        end
      end
      phase++;
    end

    wait_results_drained();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

>>> tty_input_line_discipline_top.f
rtl/tld_pkg.sv
rtl/tld_store.sv
rtl/tld_engine.sv
rtl/tty_input_line_discipline_top.sv
rtl/tld_checker.sv
tb/tb_top.sv
